// ----- src/adctf_pkg.sv -----
`default_nettype none

package adctf_pkg;

    // Default parameter values.
    localparam int TAPS_DEFAULT      = 31;
    localparam int COEF_BITS_DEFAULT = 16;

    // Field and register widths.
    localparam int SAMPLE_W = 12;
    localparam int TEMP_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Coefficients are held at 24 fraction bits; 25 signed bits cover every entry.
    localparam int COEF_COUNT = 31;
    localparam int TABLE_FRAC = 24;
    localparam int COEF_W     = 25;
    localparam int PROD_W     = TEMP_W + COEF_W;
    localparam int ACC_W      = 48;

    localparam logic [SAMPLE_W-1:0] ADC_OFFSET_RESET = 12'd1030;
    localparam logic [GAIN_W-1:0]   ADC_GAIN_RESET   = 16'd1199;

    localparam logic [CFG_IDX_W-1:0] REG_ADC_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_GAIN   = 1'b1;

    // Symmetric windowed-sinc low-pass set, units of 2^-24.
    localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_COUNT] = '{
        -25'sd18218, -25'sd13761, -25'sd6710, 25'sd10188, 25'sd45159, 25'sd105891,
        25'sd197942, 25'sd323330, 25'sd479576, 25'sd659398, 25'sd851149,
        25'sd1039975, 25'sd1209555, 25'sd1344154, 25'sd1430701, 25'sd1460556,
        25'sd1430701, 25'sd1344154, 25'sd1209555, 25'sd1039975, 25'sd851149,
        25'sd659398, 25'sd479576, 25'sd323330, 25'sd197942, 25'sd105891,
        25'sd45159, 25'sd10188, -25'sd6710, -25'sd13761, -25'sd18218
    };

    // Coefficient n rounded half up to coef_bits fraction bits; zero past the table.
    function automatic logic signed [COEF_W-1:0] coef_value(input int unsigned n,
                                                             input int coef_bits);
        int s;
        int c;
        logic signed [COEF_W-1:0] r;
        s = TABLE_FRAC - coef_bits;
        if (n >= COEF_COUNT) begin
            r = '0;
        end else begin
            c = int'(COEF_TABLE[n]);
            if (s > 0) begin
                c = (c + (1 <<< (s - 1))) >>> s;
            end
            r = COEF_W'(c);
        end
        return r;
    endfunction

    function automatic logic signed [TEMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [TEMP_W-1:0] r;
        if (v > ACC_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -ACC_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[TEMP_W-1:0];
        end
        return r;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sample;
        logic multiply;
        logic convert;
        logic read_tap;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_tap;
        logic mac_busy;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/adctf_ctrl.sv -----
`default_nettype none

module adctf_ctrl
    import adctf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_CONV  = 6'b000100,
        ST_MAC   = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.multiply = 1'b1;
                state_next   = ST_CONV;
            end
            ST_CONV: begin
                cmd.convert = 1'b1;
                state_next  = ST_MAC;
            end
            ST_MAC: begin
                cmd.read_tap = 1'b1;
                if (status.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.mac_busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hold the finished sum until the output register can take it.
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/adctf_dp.sv -----
`default_nettype none

module adctf_dp
    import adctf_pkg::*;
#(
    parameter int TAPS      = TAPS_DEFAULT,
    parameter int COEF_BITS = COEF_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [SAMPLE_W-1:0]   adc_sample,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wr_data,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [2*TEMP_W-1:0]        m_tdata
);

    localparam int PW = $clog2(TAPS);
    localparam logic [PW-1:0] LAST_POS = PW'(TAPS - 1);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (COEF_BITS - 1);
    localparam logic signed [ACC_W-1:0] CONV_HALF = ACC_W'(128);

    // Configuration registers.
    logic [SAMPLE_W-1:0] offset_reg;
    logic [GAIN_W-1:0]   gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= ADC_OFFSET_RESET;
            gain_reg   <= ADC_GAIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ADC_OFFSET: offset_reg <= cfg_wr_data[SAMPLE_W-1:0];
                REG_ADC_GAIN:   gain_reg   <= cfg_wr_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Conversion: (sample - offset) * gain, then round to Q8.8.
    logic [SAMPLE_W-1:0]       sample_reg;
    logic signed [SAMPLE_W:0]  diff;
    logic signed [29:0]        conv_prod_reg;
    logic signed [ACC_W-1:0]   conv_rnd;
    logic signed [TEMP_W-1:0]  conv_now;
    logic signed [TEMP_W-1:0]  now_reg;

    assign diff     = $signed({1'b0, sample_reg}) - $signed({1'b0, offset_reg});
    assign conv_rnd = (ACC_W'(conv_prod_reg) + CONV_HALF) >>> 8;
    assign conv_now = sat16(conv_rnd);

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= adc_sample;
        end
        if (cmd.multiply) begin
            conv_prod_reg <= diff * $signed({1'b0, gain_reg});
        end
        if (cmd.convert) begin
            now_reg <= conv_now;
        end
    end

    // Delay line memory with per-entry valid bits standing in for the cleared reset state.
    logic signed [TEMP_W-1:0] line_mem [TAPS];
    logic [TAPS-1:0]          valid_reg;
    logic [PW-1:0]            pos_reg;
    logic [PW-1:0]            rd_ptr_reg;
    logic [PW-1:0]            tap_n_reg;

    always_ff @(posedge aclk) begin
        if (cmd.convert) begin
            line_mem[pos_reg] <= conv_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            pos_reg    <= '0;
            rd_ptr_reg <= '0;
            tap_n_reg  <= '0;
        end else begin
            if (cmd.convert) begin
                valid_reg[pos_reg] <= 1'b1;
                rd_ptr_reg         <= pos_reg;
                tap_n_reg          <= '0;
                pos_reg            <= (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
            end else if (cmd.read_tap) begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_POS : rd_ptr_reg - 1'b1;
                tap_n_reg  <= tap_n_reg + 1'b1;
            end
        end
    end

    // Multiply-accumulate pipeline: read, multiply, accumulate.
    logic signed [TEMP_W-1:0] rd_data_reg;
    logic                     rd_valid_reg;
    logic [PW-1:0]            rd_n_reg;
    logic                     a_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     b_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [TEMP_W-1:0] tap_sample;

    assign tap_sample = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.read_tap) begin
            rd_data_reg <= line_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_tap) begin
            rd_valid_reg <= valid_reg[rd_ptr_reg];
            rd_n_reg     <= tap_n_reg;
        end
        if (a_vld_reg) begin
            prod_reg <= tap_sample * coef_value(int'(rd_n_reg), COEF_BITS);
        end
        if (cmd.convert) begin
            acc_reg <= '0;
        end else if (b_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= cmd.read_tap;
            b_vld_reg <= a_vld_reg;
        end
    end

    // Output register.
    logic signed [ACC_W-1:0]  acc_rnd;
    logic                     out_vld_reg;
    logic [2*TEMP_W-1:0]      out_data_reg;

    assign acc_rnd = (acc_reg + ACC_HALF) >>> COEF_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {sat16(acc_rnd), now_reg};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    assign status.last_tap = (tap_n_reg == LAST_POS);
    assign status.mac_busy = a_vld_reg | b_vld_reg;
    assign status.out_free = !out_vld_reg || m_tready;

endmodule

`default_nettype wire

// ----- src/adc_temperature_fir_lowpass_unit.sv -----
// Channel   Direction  Beat contents (low bits first)
// s_        in         tdata[11:0] adc_sample, tdata[15:12] zero
// m_        out        tdata[15:0] temp_now, tdata[31:16] temp_filtered
// cfg_      in         index 0 adc_offset, index 1 adc_gain; one write per asserted cfg_wr_en
//
// A sample is converted, then filtered by the single shared multiply-accumulate, which reads one
// delay line entry per cycle from the sample memory; then the pipeline drains.
// Reset is synchronous and active low; it restores the configuration registers and marks the line empty.
// The result waits in an output register, so a new sample is taken while it is unread;
// the filter stalls only when a second result is ready before the first has left.
`default_nettype none

module adc_temperature_fir_lowpass_unit
    import adctf_pkg::*;
#(
    parameter int TAPS      = TAPS_DEFAULT,
    parameter int COEF_BITS = COEF_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,     // [11:0] adc_sample
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [2*TEMP_W-1:0]        m_tdata,     // [15:0] temp_now, [31:16] temp_filtered
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wr_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    adctf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adctf_dp #(
        .TAPS      (TAPS),
        .COEF_BITS (COEF_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adc_sample  (s_tdata[SAMPLE_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

// ----- src/adctf_chk.sv -----
`default_nettype none

module adctf_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result beat holds its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Samples are worked one at a time: the cycle after a sample beat takes no other.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample taken while one is in work");

    // A result never appears in the cycle right after a sample beat.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too soon after a sample");

endmodule

bind adc_temperature_fir_lowpass_unit adctf_chk u_adctf_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
